// ===== hdl/mfek_pkg.sv =====
// Shared constants and types for the max-flow engine.
package mfek_pkg;
    localparam int unsigned MaxNodesDefault = 256;
    localparam int unsigned CapW = 32;
    localparam int unsigned CmdW = 2;
    localparam int unsigned NodeW = 8;
    localparam int unsigned CntW = 9;
    localparam int unsigned InCapW = 24;

    localparam logic [CmdW-1:0] CMD_ADD     = 2'd0;
    localparam logic [CmdW-1:0] CMD_COMPUTE = 2'd1;
    localparam logic [CmdW-1:0] CMD_CLEAR   = 2'd2;

    localparam logic [1:0] REG_NODE_COUNT = 2'd0;
    localparam logic [1:0] REG_SOURCE     = 2'd1;
    localparam logic [1:0] REG_SINK       = 2'd2;

    localparam logic [CapW-1:0] CapMax = '1;

    typedef logic [CapW-1:0] t_cap;

    function automatic t_cap sat_add(input t_cap a, input t_cap b);
        logic [CapW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CapW] ? CapMax : s[CapW-1:0];
    endfunction
endpackage

// ===== hdl/max_flow_edmonds_karp.sv =====
// Top level of the Edmonds-Karp max-flow engine.
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | i_valid/o_stall, command, nodes, capacity | item in
//  out     | o_valid/i_stall, o_max_flow               | item out
//  cfg     | i_cfg_we, i_cfg_index, i_cfg_data         | register write
//
// An add edge steps through accept, matrix read and write back. A clear sweeps
// the matrix one entry a cycle; reset runs the same sweep before the first
// item is taken. A compute runs a breadth-first search from the source, then
// walks each path found from the sink twice, first for the bottleneck and then
// for the update, and repeats until no path to the sink is left.
// A result waits in the output register while i_stall is high; the next
// item is taken only once the result has left.
module max_flow_edmonds_karp
    import mfek_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [CmdW-1:0]     i_command,
    input  logic [NodeW-1:0]    i_from_node,
    input  logic [NodeW-1:0]    i_to_node,
    input  logic [InCapW-1:0]   i_capacity,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [CapW-1:0]     o_max_flow,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [CntW-1:0]     i_cfg_data
);
    localparam int unsigned MAX_NODES = MaxNodesDefault;
    localparam int unsigned NW = $clog2(MAX_NODES);
    localparam int unsigned AW = 2 * NW;
    localparam int unsigned QW = NW + 1;
    localparam logic [QW-1:0] NMAX = QW'(MAX_NODES);

    // state codes
    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_ADDR  = 4'd2;
    localparam logic [3:0] S_ADDW  = 4'd3;
    localparam logic [3:0] S_BINIT = 4'd4;
    localparam logic [3:0] S_DEQ   = 4'd5;
    localparam logic [3:0] S_SCAN  = 4'd6;
    localparam logic [3:0] S_SCHK  = 4'd7;
    localparam logic [3:0] S_BN    = 4'd8;
    localparam logic [3:0] S_BNW   = 4'd9;
    localparam logic [3:0] S_UPF   = 4'd10;
    localparam logic [3:0] S_UPFW  = 4'd11;
    localparam logic [3:0] S_UPB   = 4'd12;
    localparam logic [3:0] S_UPBW  = 4'd13;
    localparam logic [3:0] S_OUT   = 4'd14;
    localparam logic [3:0] S_QRD   = 4'd15;

    logic [3:0]      r_state, n_state;
    logic [CntW-1:0] r_ncount;
    logic [NodeW-1:0] r_src, r_dst;
    logic [AW:0]     r_clr;
    logic [NW-1:0]   r_from, r_to;
    logic [InCapW-1:0] r_cap;
    logic            r_from_ok;
    logic [QW-1:0]   r_n;
    logic [NW-1:0]   r_u, r_v, r_cur;
    logic [QW-1:0]   r_head, r_tail;
    logic [MAX_NODES-1:0] r_vis;
    logic [CapW-1:0] r_bn;
    logic [CapW-1:0] r_total;
    logic [CapW-1:0] r_out;
    logic            r_ovalid;
    logic            r_mode; // 0: bottleneck walk, 1: update walk

    // matrix RAM
    logic            m_we;
    logic [AW-1:0]   m_addr;
    logic [CapW-1:0] m_wdata, m_rdata;
    mfek_ram #(.Width(CapW), .Depth(MAX_NODES * MAX_NODES)) u_mat (
        .i_clk(i_clk), .i_we(m_we), .i_addr(m_addr),
        .i_wdata(m_wdata), .o_rdata(m_rdata)
    );

    // parent RAM
    logic            p_we;
    logic [NW-1:0]   p_addr, p_wdata, p_rdata;
    mfek_ram #(.Width(NW), .Depth(MAX_NODES)) u_par (
        .i_clk(i_clk), .i_we(p_we), .i_addr(p_addr),
        .i_wdata(p_wdata), .o_rdata(p_rdata)
    );

    // queue RAM
    logic            q_we;
    logic [NW-1:0]   q_addr, q_wdata, q_rdata;
    mfek_ram #(.Width(NW), .Depth(MAX_NODES)) u_que (
        .i_clk(i_clk), .i_we(q_we), .i_addr(q_addr),
        .i_wdata(q_wdata), .o_rdata(q_rdata)
    );

    logic in_acc;
    assign o_stall = (r_state != S_IDLE) || r_ovalid;
    assign in_acc  = i_valid && !o_stall;
    assign o_valid = r_ovalid;
    assign o_max_flow = r_out;

    logic [QW-1:0] n_eff;
    assign n_eff = (r_ncount > CntW'(MAX_NODES)) ? NMAX : QW'(r_ncount);

    logic last_v;
    assign last_v = (QW'(r_v) == r_n - QW'(1));

    // sequencer
    always_comb begin
        n_state = r_state;
        m_we = 1'b0; m_addr = '0; m_wdata = '0;
        p_we = 1'b0; p_addr = r_v; p_wdata = r_u;
        q_we = 1'b0; q_addr = r_head[NW-1:0]; q_wdata = r_v;
        unique case (r_state)
            S_CLR: begin
                m_we = 1'b1; m_addr = r_clr[AW-1:0];
                if (r_clr == (AW+1)'(MAX_NODES * MAX_NODES - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                m_addr = {i_from_node[NW-1:0], i_to_node[NW-1:0]};
                if (in_acc) begin
                    case (i_command)
                        CMD_ADD:     n_state = S_ADDR;
                        CMD_COMPUTE: n_state = S_BINIT;
                        CMD_CLEAR:   n_state = S_CLR;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_ADDR: begin
                m_addr = {r_from, r_to};
                n_state = S_ADDW;
            end
            S_ADDW: begin
                m_addr = {r_from, r_to};
                m_we = r_from_ok;
                m_wdata = sat_add(m_rdata, CapW'(r_cap));
                n_state = S_IDLE;
            end
            S_BINIT: begin
                // start one search: source goes to queue slot 0
                q_we = 1'b1; q_addr = '0; q_wdata = r_src[NW-1:0];
                if (QW'(r_src) >= r_n || QW'(r_dst) >= r_n
                        || r_src == r_dst) n_state = S_OUT;
                else n_state = S_QRD;
            end
            S_QRD: begin
                q_addr = r_head[NW-1:0];
                n_state = (r_head == r_tail) ? S_BN : S_DEQ;
            end
            S_DEQ: begin
                m_addr = {q_rdata, NW'(0)};
                n_state = S_SCAN;
            end
            S_SCAN: begin
                // m_rdata holds entry (u, v); issue read of next column
                m_addr = {r_u, r_v + NW'(1)};
                if (!r_vis[r_v] && m_rdata != '0) begin
                    p_we = 1'b1;
                    q_we = (r_tail < NMAX); q_addr = r_tail[NW-1:0];
                end
                if (last_v) n_state = S_QRD;
            end
            S_SCHK: n_state = S_IDLE;
            S_BN: begin
                // walk parent chain from sink: read parent of r_cur
                p_addr = r_cur;
                if (!r_vis[r_dst[NW-1:0]]) n_state = S_OUT;
                else if (r_cur == r_src[NW-1:0]) n_state = S_UPF;
                else n_state = S_BNW;
            end
            S_BNW: begin
                p_addr = r_cur;
                m_addr = {p_rdata, r_cur};
                n_state = S_SCHK;
            end
            S_UPF: begin
                p_addr = r_cur;
                if (r_cur == r_src[NW-1:0]) n_state = S_BINIT;
                else n_state = S_UPFW;
            end
            S_UPFW: begin
                m_addr = {p_rdata, r_cur};
                n_state = S_UPB;
            end
            S_UPB: begin
                m_addr = {r_u, r_cur};
                m_we = 1'b1; m_wdata = m_rdata - r_bn;
                n_state = S_UPBW;
            end
            S_UPBW: begin
                m_addr = {r_cur, r_u};
                n_state = S_SCHK;
            end
            S_OUT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        // shared reuse of S_SCHK as the backward write / bottleneck compare
        if (r_state == S_SCHK) begin
            if (r_mode) begin
                m_addr = {r_cur, r_u};
                m_we = 1'b1; m_wdata = sat_add(m_rdata, r_bn);
                n_state = S_UPF;
            end else begin
                // source reached: start the update walk from the sink
                n_state = (r_u == r_src[NW-1:0]) ? S_UPF : S_BN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
            r_ncount <= CntW'(2);
            r_src    <= NodeW'(0);
            r_dst    <= NodeW'(1);
            r_mode   <= 1'b0;
            r_head   <= '0;
            r_tail   <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_NODE_COUNT: r_ncount <= i_cfg_data;
                    REG_SOURCE:     r_src <= i_cfg_data[NodeW-1:0];
                    REG_SINK:       r_dst <= i_cfg_data[NodeW-1:0];
                    default: ;
                endcase
            end
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            case (r_state)
                S_CLR: r_clr <= r_clr + (AW+1)'(1);
                S_IDLE: begin
                    r_clr <= '0;
                    if (in_acc) begin
                        r_total <= '0;
                    end
                end
                S_BINIT: begin
                    r_vis <= {{(MAX_NODES-1){1'b0}}, 1'b1} << r_src[NW-1:0];
                    r_head <= '0;
                    r_tail <= QW'(1);
                    r_mode <= 1'b0;
                    r_bn <= CapMax;
                    r_cur <= r_dst[NW-1:0];
                end
                S_QRD: r_head <= r_head + QW'(1);
                S_DEQ: begin
                    r_u <= q_rdata;
                    r_v <= '0;
                end
                S_SCAN: begin
                    if (!r_vis[r_v] && m_rdata != '0) begin
                        r_vis[r_v] <= 1'b1;
                        if (r_tail < NMAX) r_tail <= r_tail + QW'(1);
                    end
                    r_v <= r_v + NW'(1);
                end
                S_BNW: r_u <= p_rdata;
                S_SCHK: begin
                    if (!r_mode) begin
                        if (m_rdata < r_bn) r_bn <= m_rdata;
                        if (r_u == r_src[NW-1:0]) begin
                            r_mode <= 1'b1;
                            r_cur <= r_dst[NW-1:0];
                        end else begin
                            r_cur <= r_u;
                        end
                    end else begin
                        r_cur <= r_u;
                    end
                end
                S_BN: if (r_cur == r_src[NW-1:0]) begin
                    r_mode <= 1'b1;
                    r_cur <= r_dst[NW-1:0];
                end
                S_UPFW: r_u <= p_rdata;
                S_UPF: if (r_cur == r_src[NW-1:0]) begin
                    r_total <= sat_add(r_total, r_bn);
                end
                S_OUT: begin
                    r_out <= r_total;
                    r_ovalid <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // capture of the accepted item and the effective node count
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_from <= i_from_node[NW-1:0];
            r_to   <= i_to_node[NW-1:0];
            r_cap  <= i_capacity;
            r_from_ok <= (QW'(i_from_node) < NMAX) && (QW'(i_to_node) < NMAX);
            r_n    <= n_eff;
        end
    end

    // result shows up only after a compute
    a_out_after_compute: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state) == S_OUT)
        else $error("result without compute");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall)
        else $error("item taken while busy");
    a_tail_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail <= NMAX)
        else $error("queue tail overrun");
endmodule

// ===== hdl/mfek_ram.sv =====
// Generic single-port synchronous RAM with registered read.
module mfek_ram #(
    parameter int unsigned Width = 32,
    parameter int unsigned Depth = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
